FILE: hdl/rbs_pkg.sv
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared types and constants for the radio burst scheduler.
// ----------------------------------------------------------------------------
package rbs_pkg;

    localparam int unsigned CFG_W    = 16;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned TMS_W    = 26;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [1:0] OP_TIMER     = 2'd0;
    localparam logic [1:0] OP_LINK_UP   = 2'd1;
    localparam logic [1:0] OP_LINK_DOWN = 2'd2;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ADV  = 2'd1;
    localparam logic [1:0] PH_SCAN = 2'd2;
    localparam logic [1:0] PH_WAIT = 2'd3;

    localparam logic [2:0] CMD_NONE       = 3'd0;
    localparam logic [2:0] CMD_START_SCAN = 3'd1;
    localparam logic [2:0] CMD_START_ADV  = 3'd2;
    localparam logic [2:0] CMD_STOP_SCAN  = 3'd3;
    localparam logic [2:0] CMD_STOP_ADV   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_ADV_INTERVAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADV_BURST     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_BURST    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SLEEP     = 3'd6;

    localparam logic [CFG_W-1:0] RST_ADV_INTERVAL  = 16'd5;
    localparam logic [CFG_W-1:0] RST_SCAN_INTERVAL = 16'd15;
    localparam logic [CFG_W-1:0] RST_ADV_BURST     = 16'd250;
    localparam logic [CFG_W-1:0] RST_SCAN_BURST    = 16'd500;
    localparam logic [CFG_W-1:0] RST_SETTLE        = 16'd100;
    localparam logic [CFG_W-1:0] RST_RETRY         = 16'd1000;
    localparam logic [CFG_W-1:0] RST_MIN_SLEEP     = 16'd100;

    localparam logic [9:0] MS_PER_S = 10'd1000;

    typedef struct packed {
        logic [1:0]        op;
        logic [TIME_W-1:0] now_s;
        logic              radio_ok;
        logic              link_ok;
    } in_word_t;

    typedef struct packed {
        logic [2:0]       command;
        logic             arm_timer;
        logic [TMS_W-1:0] timer_ms;
        logic             clear_table;
        logic [1:0]       phase_now;
    } out_word_t;

    typedef struct packed {
        logic [CFG_W-1:0] adv_interval_s;
        logic [CFG_W-1:0] scan_interval_s;
        logic [CFG_W-1:0] adv_burst_ms;
        logic [CFG_W-1:0] scan_burst_ms;
        logic [CFG_W-1:0] settle_ms;
        logic [CFG_W-1:0] retry_ms;
        logic [CFG_W-1:0] min_sleep_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        phase;
        logic              linked;
        logic              expiry_pending;
        logic [TIME_W-1:0] last_adv_time;
        logic [TIME_W-1:0] last_scan_time;
    } sched_state_t;

endpackage

FILE: hdl/radio_burst_scheduler.sv
// ----------------------------------------------------------------------------
// radio_burst_scheduler
// Scan/advertise burst scheduler driven by timer and link events.
// The decision is one registered pass from the input to the output register.
// Throughput: one event word per cycle while the output is not stalled.
// Reset: async active low; registers return to defaults, phase idle, times 0.
// ----------------------------------------------------------------------------
module radio_burst_scheduler
    import rbs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_word_t             in_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_word_t            out_word
);

    cfg_t         cfg;
    sched_state_t st_reg;
    sched_state_t st_next;
    out_word_t    res;
    logic         in_valid_reg;
    logic         in_valid_next;
    in_word_t     in_word_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    out_word_t    out_word_reg;
    logic         advance;
    logic         accept;

    rbs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rbs_decide u_decide (
        .item    (in_word_reg),
        .st      (st_reg),
        .cfg     (cfg),
        .st_next (st_next),
        .res     (res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '{phase: PH_IDLE, linked: 1'b0, expiry_pending: 1'b0,
                               last_adv_time: '0, last_scan_time: '0};
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_word_reg <= in_word;
        if (advance)
            out_word_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_timer_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.arm_timer || out_word.timer_ms == '0))
        else $error("timer_ms nonzero without arm");

    a_clear_scan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.clear_table |-> out_word.command == CMD_START_SCAN)
        else $error("table clear without scan start");

    a_stop_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.arm_timer &&
        (out_word.command == CMD_STOP_SCAN || out_word.command == CMD_STOP_ADV)
        |-> out_word.phase_now == PH_WAIT)
        else $error("settle timer armed outside waiting phase");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output free");

endmodule

FILE: hdl/rbs_cfg_regs.sv
// ----------------------------------------------------------------------------
// rbs_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module rbs_cfg_regs
    import rbs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ADV_INTERVAL:  cfg_next.adv_interval_s  = cfg_data;
                REG_SCAN_INTERVAL: cfg_next.scan_interval_s = cfg_data;
                REG_ADV_BURST:     cfg_next.adv_burst_ms    = cfg_data;
                REG_SCAN_BURST:    cfg_next.scan_burst_ms   = cfg_data;
                REG_SETTLE:        cfg_next.settle_ms       = cfg_data;
                REG_RETRY:         cfg_next.retry_ms        = cfg_data;
                REG_MIN_SLEEP:     cfg_next.min_sleep_ms    = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.adv_interval_s  <= RST_ADV_INTERVAL;
            cfg_reg.scan_interval_s <= RST_SCAN_INTERVAL;
            cfg_reg.adv_burst_ms    <= RST_ADV_BURST;
            cfg_reg.scan_burst_ms   <= RST_SCAN_BURST;
            cfg_reg.settle_ms       <= RST_SETTLE;
            cfg_reg.retry_ms        <= RST_RETRY;
            cfg_reg.min_sleep_ms    <= RST_MIN_SLEEP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/rbs_decide.sv
// ----------------------------------------------------------------------------
// rbs_decide
// Next-state and result logic for one event word.
// ----------------------------------------------------------------------------
module rbs_decide
    import rbs_pkg::*;
(
    input  in_word_t     item,
    input  sched_state_t st,
    input  cfg_t         cfg,
    output sched_state_t st_next,
    output out_word_t    res
);

    logic              run;
    logic [1:0]        ph_dec;
    logic [TIME_W-1:0] since_a;
    logic [TIME_W-1:0] since_s;
    logic [TIME_W-1:0] ival_a;
    logic [TIME_W-1:0] ival_s;
    logic              adv_due;
    logic              scan_ready;
    logic [CFG_W-1:0]  rem_a;
    logic [CFG_W-1:0]  rem_s;
    logic [CFG_W-1:0]  rem_min;
    logic [TMS_W-1:0]  sleep_ms;
    logic [TMS_W-1:0]  min_sleep;

    assign ival_a    = {16'd0, cfg.adv_interval_s};
    assign ival_s    = {16'd0, cfg.scan_interval_s};
    assign min_sleep = {10'd0, cfg.min_sleep_ms};

    always_comb
    begin
        st_next = st;
        res     = '0;
        run     = 1'b0;
        ph_dec  = st.phase;
        since_a = item.now_s - st.last_adv_time;
        since_s = item.now_s - st.last_scan_time;

        case (item.op)
            OP_TIMER:
            begin
                st_next.expiry_pending = 1'b1;
                run = !st.linked;
            end
            OP_LINK_UP:
            begin
                if (item.link_ok)
                begin
                    st_next.linked = 1'b1;
                    if (st.phase == PH_ADV)
                    begin
                        res.command = CMD_STOP_ADV;
                        if (item.radio_ok)
                            st_next.phase = PH_WAIT;
                    end
                    else if (st.phase == PH_SCAN)
                    begin
                        res.command = CMD_STOP_SCAN;
                        if (item.radio_ok)
                            st_next.phase = PH_WAIT;
                    end
                end
            end
            OP_LINK_DOWN:
            begin
                st_next.linked         = 1'b0;
                st_next.phase          = PH_IDLE;
                st_next.last_adv_time  = item.now_s - ival_a;
                st_next.last_scan_time = item.now_s - ival_s;
                ph_dec  = PH_IDLE;
                since_a = ival_a;
                since_s = ival_s;
                run     = st.expiry_pending;
            end
            default:
            begin
                run = 1'b0;
            end
        endcase

        adv_due    = (item.now_s != '0) && (since_a >= ival_a);
        scan_ready = (item.now_s != '0) && (since_s >= ival_s);
        rem_a    = (since_a >= ival_a) ? '0 : cfg.adv_interval_s - since_a[CFG_W-1:0];
        rem_s    = (since_s >= ival_s) ? '0 : cfg.scan_interval_s - since_s[CFG_W-1:0];
        rem_min  = (rem_a < rem_s) ? rem_a : rem_s;
        sleep_ms = {10'd0, rem_min} * {16'd0, MS_PER_S};
        if (sleep_ms < min_sleep)
            sleep_ms = min_sleep;

        if (run)
        begin
            st_next.expiry_pending = 1'b0;
            if (ph_dec == PH_SCAN)
            begin
                res.command = CMD_STOP_SCAN;
                if (item.radio_ok)
                begin
                    st_next.phase          = PH_WAIT;
                    st_next.last_scan_time = item.now_s;
                    res.arm_timer          = 1'b1;
                    res.timer_ms           = {10'd0, cfg.settle_ms};
                end
            end
            else if (ph_dec == PH_ADV)
            begin
                res.command = CMD_STOP_ADV;
                if (item.radio_ok)
                begin
                    st_next.phase         = PH_WAIT;
                    st_next.last_adv_time = item.now_s;
                    res.arm_timer         = 1'b1;
                    res.timer_ms          = {10'd0, cfg.settle_ms};
                end
            end
            else if (scan_ready && ph_dec == PH_IDLE)
            begin
                res.command     = CMD_START_SCAN;
                res.clear_table = 1'b1;
                res.arm_timer   = 1'b1;
                if (item.radio_ok)
                begin
                    st_next.phase = PH_SCAN;
                    res.timer_ms  = {10'd0, cfg.scan_burst_ms};
                end
                else
                begin
                    res.timer_ms  = {10'd0, cfg.retry_ms};
                end
            end
            else if (adv_due && ph_dec == PH_IDLE)
            begin
                res.command   = CMD_START_ADV;
                res.arm_timer = 1'b1;
                if (item.radio_ok)
                begin
                    st_next.phase = PH_ADV;
                    res.timer_ms  = {10'd0, cfg.adv_burst_ms};
                end
                else
                begin
                    res.timer_ms  = {10'd0, cfg.retry_ms};
                end
            end
            else
            begin
                st_next.phase = PH_IDLE;
                res.arm_timer = 1'b1;
                res.timer_ms  = sleep_ms;
            end
        end

        res.phase_now = st_next.phase;
    end

endmodule
